### src/cefifo_pkg.sv
// Package for the CR/LF expanding packet FIFO: request and result structs,
// character codes, function codes and parameter defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cefifo_pkg;

	localparam int unsigned RING_DEPTH_DEF = 512;
	localparam int unsigned PACKET_MAX_DEF = 64;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_SEND = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_packet;
	} tx_item_t;

endpackage

`default_nettype wire

### src/crlf_expanding_packet_fifo.sv
// Ring-buffer byte queue with CR/LF expansion and packet drain.
// Depends on cefifo_pkg for the request and result types and constants.
`timescale 1ns / 1ps
`default_nettype none

// Byte queue for a USB IN endpoint. A push request with func 0 stores its
// byte; a CR or LF byte is stored as the pair CR, LF, the LF written from a
// separate LF state while the command side is stalled. A byte that finds the
// ring full is dropped. A send request with func 1 drains min(fill,
// PACKET_MAX) bytes in order, one byte per cycle while the result side takes
// them, and marks the last one; the command side is stalled until every byte
// of the packet has been read from the ring, so stalls on the result side
// hold the command side too. The pace is set by the single read port of the
// ring memory, whose read data register is the result register. The ring has
// one write port and one registered read port; its contents are never
// cleared, and only queued entries are read, so the block is ready straight
// after reset.
module crlf_expanding_packet_fifo
	import cefifo_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
	parameter int unsigned PACKET_MAX = PACKET_MAX_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd,
	output logic           tx_valid,
	input  wire logic      tx_stall,
	output tx_item_t       tx
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
	localparam int unsigned PKT_W = $clog2(PACKET_MAX + 1);
	localparam int unsigned CMP_W = (CNT_W > PKT_W) ? CNT_W : PKT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LF   = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	logic [7:0] ring_mem [RING_DEPTH];

	logic [1:0]       state_q, state_d;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [PKT_W-1:0] remain_q, remain_d;
	logic             tx_valid_q;
	logic [7:0]       rd_byte_s1;
	logic             last_s1;

	logic             cmd_acc;
	logic             full;
	logic             is_eol;
	logic             wr_en;
	logic [7:0]       wr_byte;
	logic             rd_en;
	logic [PKT_W-1:0] take;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign full      = (fill_q == CNT_W'(RING_DEPTH));
	assign is_eol    = (cmd.data_byte == CHAR_CR) || (cmd.data_byte == CHAR_LF);

	// packet length, clipped to the packet limit
	assign take = (CMP_W'(fill_q) > CMP_W'(PACKET_MAX)) ? PKT_W'(PACKET_MAX)
		: PKT_W'(fill_q);

	// a new read only when the result register is free or being emptied
	assign rd_en = (state_q == ST_SEND) && (!tx_valid_q || !tx_stall);

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		remain_d = remain_q;
		wr_en    = 1'b0;
		wr_byte  = cmd.data_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					if (cmd.func == FUNC_PUSH) begin
						wr_en = !full;
						if (is_eol) begin
							wr_byte = CHAR_CR;
							state_d = ST_LF;
						end
					end else if (take != '0) begin
						fill_d   = fill_q - CNT_W'(take);
						remain_d = take;
						state_d  = ST_SEND;
					end
				end
			end
			ST_LF: begin
				wr_en   = !full;
				wr_byte = CHAR_LF;
				state_d = ST_IDLE;
			end
			ST_SEND: begin
				if (rd_en) begin
					remain_d = remain_q - PKT_W'(1);
					if (remain_q == PKT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (wr_en) begin
			fill_d = fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			remain_q   <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			tx_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			remain_q <= remain_d;
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q   <= (rd_ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
				tx_valid_q <= 1'b1;
			end else if (!tx_stall) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_ptr_q] <= wr_byte;
		end
		if (rd_en) begin
			rd_byte_s1 <= ring_mem[rd_ptr_q];
			last_s1    <= (remain_q == PKT_W'(1));
		end
	end

	assign tx_valid          = tx_valid_q;
	assign tx.out_byte       = rd_byte_s1;
	assign tx.last_of_packet = last_s1;

endmodule

`default_nettype wire
